[rtl/rdbem_pkg.sv]
package rdbem_pkg;

    localparam int unsigned MAIN_BYTES  = 65536;
    localparam int unsigned FRAME_BYTES = 65536;
    localparam int unsigned GPU_BYTES   = 16384;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned SIZE_W  = 2;
    localparam int unsigned INDEX_W = 2;

    localparam int unsigned NUM_BANKS  = 8;
    localparam int unsigned BANK_SEL_W = $clog2(NUM_BANKS);
    localparam int unsigned NBYTES_W   = BANK_SEL_W + 1;

    localparam int unsigned MAX_BYTES =
        (MAIN_BYTES > FRAME_BYTES)
            ? ((MAIN_BYTES > GPU_BYTES) ? MAIN_BYTES : GPU_BYTES)
            : ((FRAME_BYTES > GPU_BYTES) ? FRAME_BYTES : GPU_BYTES);
    localparam int unsigned OFS_W = $clog2(MAX_BYTES);

    localparam int unsigned BANK_ROWS = (MAIN_BYTES + FRAME_BYTES + GPU_BYTES) / NUM_BANKS;
    localparam int unsigned ROW_W     = $clog2(BANK_ROWS);

    localparam logic [OFS_W-1:0] MAIN_MASK  = OFS_W'(MAIN_BYTES - 1);
    localparam logic [OFS_W-1:0] FRAME_MASK = OFS_W'(FRAME_BYTES - 1);
    localparam logic [OFS_W-1:0] GPU_MASK   = OFS_W'(GPU_BYTES - 1);

    localparam logic [ROW_W-1:0] MAIN_ROW_BASE  = '0;
    localparam logic [ROW_W-1:0] FRAME_ROW_BASE = ROW_W'(MAIN_BYTES / NUM_BANKS);
    localparam logic [ROW_W-1:0] GPU_ROW_BASE   =
        ROW_W'((MAIN_BYTES + FRAME_BYTES) / NUM_BANKS);

    localparam logic [ADDR_W-1:0] MAIN_LIMIT_RESET  = 32'h0FFF_FFFF;
    localparam logic [ADDR_W-1:0] FRAME_LIMIT_RESET = 32'h1FBF_FFFE;
    localparam logic [ADDR_W-1:0] GPU_LIMIT_RESET   = 32'h1FFF_FFFD;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [INDEX_W-1:0] {
        CFG_MAIN_LIMIT  = 2'd0,
        CFG_FRAME_LIMIT = 2'd1,
        CFG_GPU_LIMIT   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        REGION_MAIN  = 2'd0,
        REGION_FRAME = 2'd1,
        REGION_GPU   = 2'd2,
        REGION_NONE  = 2'd3
    } region_t;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        region_t           region;
    } rsp_t;

    function automatic logic [OFS_W-1:0] region_mask(region_t r);
        logic [OFS_W-1:0] m;
        case (r)
            REGION_MAIN:  m = MAIN_MASK;
            REGION_FRAME: m = FRAME_MASK;
            REGION_GPU:   m = GPU_MASK;
            default:      m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] region_row_base(region_t r);
        logic [ROW_W-1:0] b;
        case (r)
            REGION_MAIN:  b = MAIN_ROW_BASE;
            REGION_FRAME: b = FRAME_ROW_BASE;
            REGION_GPU:   b = GPU_ROW_BASE;
            default:      b = '0;
        endcase
        return b;
    endfunction

endpackage

[rtl/rdbem_if.sv]
interface rdbem_req_if
    import rdbem_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size_code;
    logic [DATA_W-1:0] write_data;

    modport source (
        output valid,
        input  ready,
        output command,
        output address,
        output size_code,
        output write_data
    );

    modport sink (
        input  valid,
        output ready,
        input  command,
        input  address,
        input  size_code,
        input  write_data
    );
endinterface

interface rdbem_rsp_if
    import rdbem_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [1:0]        region;

    modport source (
        output valid,
        input  ready,
        output read_data,
        output region
    );

    modport sink (
        input  valid,
        output ready,
        input  read_data,
        input  region
    );
endinterface

[rtl/region_decoded_big_endian_memory.sv]
// region-decoded big-endian memory
// req channel: one access per beat (command, address, size_code, write_data).
// rsp channel: one beat per access (read_data, region), in request order.
// cfg port: cfg_write/cfg_index/cfg_data set main_limit, frame_limit and
// gpu_limit (indexes 0, 1, 2); index 3 is ignored. write only while idle.
// the address is decoded against the three limits, rebased and wrapped to
// the store of its region. bytes live in eight byte-wide banks, so any
// access of up to eight bytes touches each bank at most once.
// an accepted access passes the decode register (s1), the bank read and
// s2 register, and the response buffer before its beat is offered on rsp.
// throughput: one access per cycle, set by the single port of each bank,
// while req.ready is high. at most four accesses may be accepted and not
// yet delivered; when the receiver stalls, responses collect in a
// four-entry buffer and req.ready falls once it would overflow.
// reset: limits return to their defaults and the pipeline empties; bank
// contents are kept and a byte never written reads as an unknown value.
module region_decoded_big_endian_memory
    import rdbem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]  cfg_data,
    rdbem_req_if.sink          req,
    rdbem_rsp_if.source        rsp
);

    logic [ADDR_W-1:0] main_limit_reg;
    logic [ADDR_W-1:0] frame_limit_reg;
    logic [ADDR_W-1:0] gpu_limit_reg;

    logic              s1_valid_reg;
    logic              s1_write_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    region_t           s1_region_reg;
    logic [OFS_W-1:0]  s1_offset_reg;
    logic [DATA_W-1:0] s1_wdata_reg;

    logic              s2_valid_reg;
    logic              s2_write_reg;
    logic [SIZE_W-1:0] s2_size_reg;
    region_t           s2_region_reg;
    logic [BANK_SEL_W-1:0] s2_offset_reg;

    rsp_t                  fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]      fifo_count_reg;
    logic [CNT_W-1:0]      inflight_reg;

    logic              req_fire;
    logic              rsp_fire;
    logic              push;
    region_t           region_next;
    logic [OFS_W-1:0]  offset_next;
    logic [ADDR_W-1:0] frame_off;
    logic [ADDR_W-1:0] gpu_off;

    logic [NBYTES_W-1:0]   s1_nbytes;
    logic [BANK_SEL_W-1:0] s1_last;
    logic [NUM_BANKS-1:0]  bank_en;
    logic [ROW_W-1:0]      bank_row   [NUM_BANKS];
    logic [7:0]            bank_wdata [NUM_BANKS];
    logic [7:0]            bank_rdata [NUM_BANKS];

    logic [NBYTES_W-1:0]   s2_nbytes;
    logic [BANK_SEL_W-1:0] s2_last;
    logic [DATA_W-1:0]     gather_data;
    rsp_t                  push_data;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign push     = s2_valid_reg;

    assign req.ready = (inflight_reg < CNT_W'(FIFO_DEPTH));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_limit_reg  <= MAIN_LIMIT_RESET;
            frame_limit_reg <= FRAME_LIMIT_RESET;
            gpu_limit_reg   <= GPU_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAIN_LIMIT:  main_limit_reg  <= cfg_data;
                CFG_FRAME_LIMIT: frame_limit_reg <= cfg_data;
                CFG_GPU_LIMIT:   gpu_limit_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // region decode and rebase
    assign frame_off = req.address - main_limit_reg;
    assign gpu_off   = req.address - frame_limit_reg;

    always_comb
    begin
        if (req.address < main_limit_reg)
        begin
            region_next = REGION_MAIN;
            offset_next = req.address[OFS_W-1:0] & MAIN_MASK;
        end
        else if (req.address < frame_limit_reg)
        begin
            region_next = REGION_FRAME;
            offset_next = frame_off[OFS_W-1:0] & FRAME_MASK;
        end
        else if (req.address < gpu_limit_reg)
        begin
            region_next = REGION_GPU;
            offset_next = gpu_off[OFS_W-1:0] & GPU_MASK;
        end
        else
        begin
            region_next = REGION_NONE;
            offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_write_reg  <= (req.command == CMD_WRITE);
            s1_size_reg   <= req.size_code;
            s1_region_reg <= region_next;
            s1_offset_reg <= offset_next;
            s1_wdata_reg  <= req.write_data;
        end
        if (s1_valid_reg)
        begin
            s2_write_reg  <= s1_write_reg;
            s2_size_reg   <= s1_size_reg;
            s2_region_reg <= s1_region_reg;
            s2_offset_reg <= s1_offset_reg[BANK_SEL_W-1:0];
        end
    end

    // bank address and write byte steering
    assign s1_nbytes = NBYTES_W'(1) << s1_size_reg;
    assign s1_last   = BANK_SEL_W'(s1_nbytes - NBYTES_W'(1));

    always_comb
    begin
        logic [BANK_SEL_W-1:0] k;
        logic [BANK_SEL_W-1:0] sh;
        logic [OFS_W-1:0]      sum;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            k   = BANK_SEL_W'(b) - s1_offset_reg[BANK_SEL_W-1:0];
            sh  = s1_last - k;
            sum = (s1_offset_reg + OFS_W'(k)) & region_mask(s1_region_reg);
            bank_en[b] = s1_valid_reg && (s1_region_reg != REGION_NONE)
                         && ({1'b0, k} < s1_nbytes);
            bank_row[b] = region_row_base(s1_region_reg)
                          + ROW_W'(sum[OFS_W-1:BANK_SEL_W]);
            bank_wdata[b] = s1_wdata_reg[{sh, 3'b000} +: 8];
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        rdbem_bank_ram #(
            .WIDTH (8),
            .DEPTH (BANK_ROWS)
        ) u_bank (
            .clk   (clk),
            .en    (bank_en[g]),
            .we    (s1_write_reg),
            .addr  (bank_row[g]),
            .wdata (bank_wdata[g]),
            .rdata (bank_rdata[g])
        );
    end

    // big-endian gather
    assign s2_nbytes = NBYTES_W'(1) << s2_size_reg;
    assign s2_last   = BANK_SEL_W'(s2_nbytes - NBYTES_W'(1));

    always_comb
    begin
        logic [BANK_SEL_W-1:0] bsel;
        for (int p = 0; p < NUM_BANKS; p++)
        begin
            bsel = s2_offset_reg + (s2_last - BANK_SEL_W'(p));
            if (!s2_write_reg && (s2_region_reg != REGION_NONE)
                && (NBYTES_W'(p) < s2_nbytes))
            begin
                gather_data[8*p +: 8] = bank_rdata[bsel];
            end
            else
            begin
                gather_data[8*p +: 8] = 8'h00;
            end
        end
    end

    assign push_data.read_data = gather_data;
    assign push_data.region    = s2_region_reg;

    // response buffer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            inflight_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (rsp_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fifo_count_reg <= fifo_count_reg + CNT_W'(push) - CNT_W'(rsp_fire);
            inflight_reg   <= inflight_reg + CNT_W'(req_fire) - CNT_W'(rsp_fire);
        end
    end

    assign rsp.valid     = (fifo_count_reg != '0);
    assign rsp.read_data = fifo_mem_reg[rd_ptr_reg].read_data;
    assign rsp.region    = fifo_mem_reg[rd_ptr_reg].region;

    a_inflight_balance: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == fifo_count_reg + CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg))
        else $error("in-flight count does not match pipeline and buffer contents");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(FIFO_DEPTH))
        else $error("more accesses in flight than buffer entries");

    a_bank_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(bank_en) == ((s1_valid_reg && (s1_region_reg != REGION_NONE))
                                ? int'(s1_nbytes) : 0))
        else $error("bank enables do not match access size");

    a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(req_fire, 2) && $past(rst_n, 2) |-> push)
        else $error("accepted access did not reach the response buffer");

endmodule

[rtl/rdbem_bank_ram.sv]
module rdbem_bank_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
